// ----- hdl/monochrome_framebuffer_draw_engine_macros.svh -----
// assertion macros used by the draw engine controller
`ifndef MONOCHROME_FRAMEBUFFER_DRAW_ENGINE_MACROS_SVH
`define MONOCHROME_FRAMEBUFFER_DRAW_ENGINE_MACROS_SVH

// checked on every clock edge once reset is released
`define MFDE_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// checked on every clock edge, reset included
`define MFDE_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) (prop)) else $error(msg);

`endif

// ----- hdl/mfde_pkg.sv -----
// types, constants and command codes of the framebuffer draw engine
package mfde_pkg;

  localparam int DISP_W   = 128;
  localparam int DISP_H   = 64;
  localparam int FB_PAGES = (DISP_H + 7) / 8;
  localparam int FB_BYTES = DISP_W * FB_PAGES;
  localparam int ADDR_W   = $clog2(FB_BYTES);
  localparam int CW       = 10;  // coordinate width, holds 255 + 255
  localparam int EW       = 11;  // bresenham error width

  localparam logic [2:0] K_SET_PIX = 3'd0;
  localparam logic [2:0] K_CLR_PIX = 3'd1;
  localparam logic [2:0] K_LINE    = 3'd2;
  localparam logic [2:0] K_RECT    = 3'd3;
  localparam logic [2:0] K_FILL    = 3'd4;
  localparam logic [2:0] K_CLEAR   = 3'd5;
  localparam logic [2:0] K_SCROLL  = 3'd6;
  localparam logic [2:0] K_READ    = 3'd7;

  typedef struct packed {
    logic [2:0] kind;
    logic [7:0] x_start;
    logic [7:0] y_start;
    logic [7:0] x_end_or_width;
    logic [7:0] y_end_or_height;
    logic [9:0] byte_index;
  } in_item_t;

  typedef struct packed {
    logic [2:0] done_kind;
    logic [7:0] read_data;
  } out_item_t;

  typedef enum logic [3:0] {
    OP_NONE, OP_LOAD, OP_PIX_RD, OP_PIX_WR, OP_LINE_STEP, OP_X_NEXT, OP_Y_NEXT,
    OP_SET_BOT, OP_SET_LEFT, OP_SET_RIGHT, OP_FILL_ROW, OP_BYTE_CLR, OP_SCR_RD,
    OP_SCR_WR, OP_RD_BYTE
  } dp_op_e;

  typedef enum logic [3:0] {
    S_INIT, S_IDLE, S_START, S_PLOT_RD, S_PLOT_WR, S_ADV, S_CLR, S_SCR_RD,
    S_SCR_WR, S_DONE
  } state_e;

  typedef struct packed {
    dp_op_e op;
    logic   out_load;
  } dp_cmd_t;

  typedef struct packed {
    logic [2:0] kind;
    logic       pix_ok;
    logic       line_done;
    logic       x_last;
    logic       y_last;
    logic       rect_empty;
    logic       addr_last;
    logic       move_last;
  } dp_stat_t;

endpackage

// ----- hdl/mfde_dp.sv -----
// datapath: frame memory, coordinate walkers, bresenham state, result register
module mfde_dp (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  mfde_pkg::in_item_t in_data_i,
  input  mfde_pkg::dp_cmd_t  cmd_i,
  output mfde_pkg::dp_stat_t stat_o,
  output mfde_pkg::out_item_t out_data_o
);
  import mfde_pkg::*;

  in_item_t               item_q;
  logic [CW-1:0]          cx_q, cy_q, xr_q, yb_q, x0_c, y0_c;
  logic [7:0]             dx_q, dy_q;
  logic                   sx_q, sy_q;
  logic signed [EW-1:0]   err_q, err_n, dx_s, dy_s;
  logic [CW-1:0]          cx_n, cy_n;
  logic [ADDR_W-1:0]      addr_q, pix_idx;
  logic [7:0]             mem_q [FB_BYTES];
  logic [7:0]             rdata_q, mask;
  logic                   rd_ok_q;
  logic                   mem_we, mem_re;
  logic [ADDR_W-1:0]      mem_waddr, mem_raddr;
  logic [7:0]             mem_wdata;
  out_item_t              out_q;
  logic [7:0]             in_dx, in_dy;

  assign x0_c = CW'(item_q.x_start);
  assign y0_c = CW'(item_q.y_start);
  assign dx_s = $signed({{(EW-8){1'b0}}, dx_q});
  assign dy_s = $signed({{(EW-8){1'b0}}, dy_q});

  assign in_dx = (in_data_i.x_end_or_width > in_data_i.x_start) ?
                 in_data_i.x_end_or_width - in_data_i.x_start :
                 in_data_i.x_start - in_data_i.x_end_or_width;
  assign in_dy = (in_data_i.y_end_or_height > in_data_i.y_start) ?
                 in_data_i.y_end_or_height - in_data_i.y_start :
                 in_data_i.y_start - in_data_i.y_end_or_height;

  // one bresenham step
  always_comb begin
    err_n = err_q;
    cx_n  = cx_q;
    cy_n  = cy_q;
    if (err_q > -dx_s) begin
      err_n = err_n - dy_s;
      cx_n  = sx_q ? cx_q + CW'(1) : cx_q - CW'(1);
    end
    if (err_q < dy_s) begin
      err_n = err_n + dx_s;
      cy_n  = sy_q ? cy_q + CW'(1) : cy_q - CW'(1);
    end
  end

  always_ff @(posedge clk_i) begin
    case (cmd_i.op)
      OP_LOAD: begin
        item_q <= in_data_i;
        cx_q   <= CW'(in_data_i.x_start);
        cy_q   <= CW'(in_data_i.y_start);
        xr_q   <= CW'(in_data_i.x_start) + CW'(in_data_i.x_end_or_width) - CW'(1);
        yb_q   <= CW'(in_data_i.y_start) + CW'(in_data_i.y_end_or_height) - CW'(1);
        dx_q   <= in_dx;
        dy_q   <= in_dy;
        sx_q   <= in_data_i.x_start < in_data_i.x_end_or_width;
        sy_q   <= in_data_i.y_start < in_data_i.y_end_or_height;
        err_q  <= (in_dx > in_dy) ? EW'(in_dx >> 1) : -EW'(in_dy >> 1);
      end
      OP_LINE_STEP: begin
        cx_q  <= cx_n;
        cy_q  <= cy_n;
        err_q <= err_n;
      end
      OP_X_NEXT:    cx_q <= cx_q + CW'(1);
      OP_Y_NEXT:    cy_q <= cy_q + CW'(1);
      OP_SET_BOT: begin
        cx_q <= x0_c;
        cy_q <= yb_q;
      end
      OP_SET_LEFT: begin
        cx_q <= x0_c;
        cy_q <= y0_c;
      end
      OP_SET_RIGHT: begin
        cx_q <= xr_q;
        cy_q <= y0_c;
      end
      OP_FILL_ROW: begin
        cx_q <= x0_c;
        cy_q <= cy_q + CW'(1);
      end
      OP_RD_BYTE:   rd_ok_q <= 32'(item_q.byte_index) < FB_BYTES;
      default: ;
    endcase
  end

  // sweep address for clear and scroll
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      addr_q <= '0;
    end else if (cmd_i.op == OP_LOAD) begin
      addr_q <= '0;
    end else if (cmd_i.op == OP_BYTE_CLR || cmd_i.op == OP_SCR_WR) begin
      addr_q <= stat_o.addr_last ? '0 : addr_q + ADDR_W'(1);
    end
  end

  assign pix_idx = ADDR_W'(32'(cx_q) + 32'(cy_q >> 3) * DISP_W);
  assign mask    = 8'(1) << cy_q[2:0];

  always_comb begin
    mem_we    = 1'b0;
    mem_re    = 1'b0;
    mem_waddr = addr_q;
    mem_raddr = pix_idx;
    mem_wdata = '0;
    case (cmd_i.op)
      OP_PIX_RD: mem_re = 1'b1;
      OP_PIX_WR: begin
        mem_we    = 1'b1;
        mem_waddr = pix_idx;
        mem_wdata = (item_q.kind == K_CLR_PIX) ? (rdata_q & ~mask) : (rdata_q | mask);
      end
      OP_BYTE_CLR: mem_we = 1'b1;
      OP_SCR_RD: begin
        mem_re    = 1'b1;
        mem_raddr = addr_q + ADDR_W'(DISP_W);
      end
      OP_SCR_WR: begin
        mem_we    = 1'b1;
        mem_wdata = rdata_q;
      end
      OP_RD_BYTE: begin
        mem_re    = 1'b1;
        mem_raddr = ADDR_W'(item_q.byte_index);
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) mem_q[mem_waddr] <= mem_wdata;
    if (mem_re) rdata_q <= mem_q[mem_raddr];
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.out_load) begin
      out_q.done_kind <= item_q.kind;
      out_q.read_data <= (item_q.kind == K_READ && rd_ok_q) ? rdata_q : 8'd0;
    end
  end
  assign out_data_o = out_q;

  assign stat_o.kind       = item_q.kind;
  assign stat_o.pix_ok     = (cx_q < CW'(DISP_W)) && (cy_q < CW'(DISP_H));
  assign stat_o.line_done  = (cx_q == CW'(item_q.x_end_or_width)) &&
                             (cy_q == CW'(item_q.y_end_or_height));
  assign stat_o.x_last     = cx_q == xr_q;
  assign stat_o.y_last     = cy_q == yb_q;
  assign stat_o.rect_empty = (item_q.x_end_or_width == 8'd0) ||
                             (item_q.y_end_or_height == 8'd0);
  assign stat_o.addr_last  = addr_q == ADDR_W'(FB_BYTES - 1);
  assign stat_o.move_last  = addr_q == ADDR_W'(FB_BYTES - DISP_W - 1);

endmodule

// ----- hdl/mfde_ctrl.sv -----
// controller: command sequencer and handshake
module mfde_ctrl (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  input  mfde_pkg::dp_stat_t stat_i,
  output mfde_pkg::dp_cmd_t  cmd_o
);
  import mfde_pkg::*;
  `include "monochrome_framebuffer_draw_engine_macros.svh"

  state_e     state_q, state_d;
  logic [1:0] phase_q, phase_d;
  logic       out_valid_q, out_valid_d;
  logic       slot_free;

  assign slot_free = !out_valid_q || out_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_INIT;
      phase_q     <= 2'd0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      phase_q     <= phase_d;
      out_valid_q <= out_valid_d;
    end
  end

  // next state
  always_comb begin
    state_d = state_q;
    phase_d = phase_q;
    unique case (state_q)
      S_INIT:    if (stat_i.addr_last) state_d = S_IDLE;
      S_IDLE:    if (in_valid_i) state_d = S_START;
      S_START: begin
        phase_d = 2'd0;
        case (stat_i.kind) inside
          K_RECT, K_FILL: state_d = stat_i.rect_empty ? S_DONE : S_PLOT_RD;
          K_CLEAR:        state_d = S_CLR;
          K_SCROLL:       state_d = (FB_BYTES == DISP_W) ? S_CLR : S_SCR_RD;
          K_READ:         state_d = S_DONE;
          default:        state_d = S_PLOT_RD;
        endcase
      end
      S_PLOT_RD: state_d = stat_i.pix_ok ? S_PLOT_WR : S_ADV;
      S_PLOT_WR: state_d = S_ADV;
      S_ADV: begin
        state_d = S_PLOT_RD;
        case (stat_i.kind)
          K_LINE: if (stat_i.line_done) state_d = S_DONE;
          K_RECT: begin
            if (phase_q[1] == 1'b0) begin
              if (stat_i.x_last) phase_d = phase_q + 2'd1;
            end else if (stat_i.y_last) begin
              if (phase_q == 2'd3) state_d = S_DONE;
              else phase_d = phase_q + 2'd1;
            end
          end
          K_FILL: if (stat_i.x_last && stat_i.y_last) state_d = S_DONE;
          default: state_d = S_DONE;
        endcase
      end
      S_CLR:     if (stat_i.addr_last) state_d = S_DONE;
      S_SCR_RD:  state_d = S_SCR_WR;
      S_SCR_WR:  state_d = stat_i.move_last ? S_CLR : S_SCR_RD;
      S_DONE:    if (slot_free) state_d = S_IDLE;
      default:   state_d = S_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    cmd_o.op       = OP_NONE;
    cmd_o.out_load = 1'b0;
    in_ready_o     = 1'b0;
    unique case (state_q)
      S_INIT:    cmd_o.op = OP_BYTE_CLR;
      S_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) cmd_o.op = OP_LOAD;
      end
      S_START:   if (stat_i.kind == K_READ) cmd_o.op = OP_RD_BYTE;
      S_PLOT_RD: if (stat_i.pix_ok) cmd_o.op = OP_PIX_RD;
      S_PLOT_WR: cmd_o.op = OP_PIX_WR;
      S_ADV: begin
        case (stat_i.kind)
          K_LINE: if (!stat_i.line_done) cmd_o.op = OP_LINE_STEP;
          K_RECT: begin
            case (phase_q)
              2'd0:    cmd_o.op = stat_i.x_last ? OP_SET_BOT : OP_X_NEXT;
              2'd1:    cmd_o.op = stat_i.x_last ? OP_SET_LEFT : OP_X_NEXT;
              2'd2:    cmd_o.op = stat_i.y_last ? OP_SET_RIGHT : OP_Y_NEXT;
              default: cmd_o.op = stat_i.y_last ? OP_NONE : OP_Y_NEXT;
            endcase
          end
          K_FILL: begin
            if (!stat_i.x_last) cmd_o.op = OP_X_NEXT;
            else if (!stat_i.y_last) cmd_o.op = OP_FILL_ROW;
          end
          default: ;
        endcase
      end
      S_CLR:     cmd_o.op = OP_BYTE_CLR;
      S_SCR_RD:  cmd_o.op = OP_SCR_RD;
      S_SCR_WR:  cmd_o.op = OP_SCR_WR;
      S_DONE:    cmd_o.out_load = slot_free;
      default: ;
    endcase
  end

  assign out_valid_d = (out_valid_q && !out_ready_i) || cmd_o.out_load;
  assign out_valid_o = out_valid_q;

  `MFDE_ASSERT(a_accept_leaves_idle, in_valid_i && in_ready_o |=> state_q == S_START, "accepted beat did not start a command")
  `MFDE_ASSERT(a_write_after_read, state_q == S_PLOT_WR |-> $past(state_q) == S_PLOT_RD, "pixel write without a preceding read")
  `MFDE_ASSERT(a_init_once, state_q != S_INIT |=> state_q != S_INIT, "clearing sweep entered after reset")
  `MFDE_ASSERT(a_done_loads, state_q == S_DONE && slot_free |=> out_valid_o, "finished command produced no result")
  `MFDE_ASSERT_ALWAYS(a_no_ready_in_init, state_q == S_INIT |-> !in_ready_o, "input taken during clearing sweep")

endmodule

// ----- hdl/monochrome_framebuffer_draw_engine.sv -----
// top level of the monochrome page framebuffer draw engine
// one command at a time: a new beat is taken once the previous command has finished walking
// the frame memory, every on-display pixel costing a read and a write of its byte
// after reset the frame memory is cleared by a sweep over all FB_BYTES bytes (1024 at 128x64)
// during which no input beat is accepted
module monochrome_framebuffer_draw_engine (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  mfde_pkg::in_item_t  in_data_i,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output mfde_pkg::out_item_t out_data_o
);
  import mfde_pkg::*;

  // command and status between sequencer and datapath
  dp_cmd_t  cmd;
  dp_stat_t stat;

  // the sequencer owns the handshake and the result-valid flag
  mfde_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .stat_i      (stat),
    .cmd_o       (cmd)
  );

  // the datapath holds the frame memory, the walkers and the result payload
  mfde_dp u_dp (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_data_i  (in_data_i),
    .cmd_i      (cmd),
    .stat_o     (stat),
    .out_data_o (out_data_o)
  );

endmodule
